// ===== src/alks_pkg.sv =====
// Shared types and constants for the addressable latch and keyboard scan block.
package alks_pkg;

  localparam int KEY_COLUMNS = 10;
  localparam int KEY_IDX_W   = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  // Latch bit positions with side effects.
  localparam logic [2:0] LB_SOUND_N   = 3'd0;
  localparam logic [2:0] LB_PA_SET    = 3'd1;
  localparam logic [2:0] LB_KBD_N     = 3'd3;
  localparam logic [2:0] LB_SCREEN_LO = 3'd4;
  localparam logic [2:0] LB_SCREEN_HI = 3'd5;

  typedef enum logic [1:0] {
    KIND_PORT_A = 2'd0,
    KIND_PORT_B = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_KEY    = 2'd3
  } kind_t;

  typedef struct packed {
    logic       en;
    logic [3:0] col;
    logic [7:0] rows;
  } key_wr_t;

endpackage

// ===== src/addressable_latch_keyboard_scan.sv =====
// Top level: input register, single compute stage with latch state, result register.
// Every item (port A write, port B write, scan tick, key matrix update) gives exactly one
// result. The block takes one item per clock while the result side is not stalled; an item
// accepted goes through the input register and then the result register, around one stage
// of logic that updates the latch, port A byte, scan column and key matrix and reads one
// matrix column. The key matrix is held in flip-flops and reset to no key pressed. A stall on
// the result side holds the input register, and input ready drops only while both
// registers are full and the result is not taken.
module addressable_latch_keyboard_scan (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // data_byte[7:0], key_column[11:8], key_rows[19:12], zero[23:20]
  input  logic [alks_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind[1:0]
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // port_a_value[7:0], ca2_write[8], ca2_level[9], sound_write[10], sound_byte[18:11],
  // latch_outputs[26:19], screen_update[27], zero[31:28]
  output logic [alks_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // Input register.
  logic                  s1_valid_r;
  alks_pkg::kind_t       s1_kind_r;
  logic [7:0]            s1_data_r;
  logic [3:0]            s1_kcol_r;
  logic [7:0]            s1_krows_r;

  // Block state.
  logic [7:0]            latch_r, latch_nxt;
  logic [7:0]            pa_r, pa_nxt;
  logic [3:0]            scan_r, scan_nxt;

  // Result register.
  logic                  out_valid_r;
  logic [alks_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                  advance;

  alks_pkg::key_wr_t     key_wr;
  logic [3:0]            rd_col;
  logic [7:0]            rd_rows;

  logic [7:0]            lk_byte;
  logic                  pressed;
  logic                  any_key;
  logic [7:0]            lk_result;
  logic                  ca2_w, ca2_l, snd_w, scr;
  logic [7:0]            snd_b;
  logic [2:0]            bit_idx;
  logic                  bit_val;
  logic                  bit_change;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r  <= alks_pkg::kind_t'(in_tuser);
      s1_data_r  <= in_tdata[7:0];
      s1_kcol_r  <= in_tdata[11:8];
      s1_krows_r <= in_tdata[19:12];
    end
  end

  alks_keymat u_keymat (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (key_wr),
    .rd_col  (rd_col),
    .rd_rows (rd_rows)
  );

  // A port A write looks up the incoming byte; a keyboard-enable edge looks up the stored one.
  assign lk_byte   = (s1_kind_r == alks_pkg::KIND_PORT_A) ? s1_data_r : pa_r;
  assign rd_col    = (s1_kind_r == alks_pkg::KIND_TICK) ? scan_r + 4'd1 : lk_byte[3:0];
  assign pressed   = ~rd_rows[lk_byte[6:4]];
  assign any_key   = (rd_rows | 8'h01) != 8'hff;
  assign lk_result = {pressed, lk_byte[6:0]};

  assign bit_idx    = s1_data_r[2:0];
  assign bit_val    = s1_data_r[3];
  assign bit_change = latch_r[bit_idx] != bit_val;

  always_comb begin
    latch_nxt   = latch_r;
    pa_nxt      = pa_r;
    scan_nxt    = scan_r;
    ca2_w       = 1'b0;
    ca2_l       = 1'b0;
    snd_w       = 1'b0;
    snd_b       = 8'h00;
    scr         = 1'b0;
    key_wr.en   = 1'b0;
    key_wr.col  = s1_kcol_r;
    key_wr.rows = s1_krows_r;
    unique case (s1_kind_r)
      alks_pkg::KIND_PORT_A: begin
        pa_nxt = s1_data_r;
        if (!latch_r[alks_pkg::LB_SOUND_N]) begin
          snd_w = 1'b1;
          snd_b = s1_data_r;
        end
        if (!latch_r[alks_pkg::LB_KBD_N]) begin
          pa_nxt   = lk_result;
          scan_nxt = lk_byte[3:0];
          ca2_w    = 1'b1;
          ca2_l    = any_key;
        end
      end
      alks_pkg::KIND_PORT_B: begin
        if (bit_change) begin
          latch_nxt[bit_idx] = bit_val;
          scr = (bit_idx == alks_pkg::LB_SCREEN_LO) || (bit_idx == alks_pkg::LB_SCREEN_HI);
          if (!bit_val) begin
            if (bit_idx == alks_pkg::LB_SOUND_N) begin
              snd_w = 1'b1;
              snd_b = pa_r;
            end else if (bit_idx == alks_pkg::LB_PA_SET) begin
              pa_nxt = 8'hff;
            end else if (bit_idx == alks_pkg::LB_KBD_N) begin
              pa_nxt   = lk_result;
              scan_nxt = lk_byte[3:0];
              ca2_w    = 1'b1;
              ca2_l    = any_key;
            end
          end
        end
      end
      alks_pkg::KIND_TICK: begin
        // Auto-scan runs only while the keyboard is disabled.
        if (latch_r[alks_pkg::LB_KBD_N]) begin
          scan_nxt = rd_col;
          ca2_w    = 1'b1;
          ca2_l    = any_key;
        end
      end
      alks_pkg::KIND_KEY: begin
        key_wr.en = advance;
      end
      default: begin
      end
    endcase
  end

  assign out_data_nxt = {4'b0000, scr, latch_nxt, snd_b, snd_w, ca2_l, ca2_w, pa_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r     <= 8'hff;
      pa_r        <= 8'h00;
      scan_r      <= 4'h0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        latch_r     <= latch_nxt;
        pa_r        <= pa_nxt;
        scan_r      <= scan_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/alks_keymat.sv =====
// Key matrix storage: one row byte per column, one write and one read port.
module alks_keymat (
  input  logic              clk,
  input  logic              rst_n,
  input  alks_pkg::key_wr_t wr,
  input  logic [3:0]        rd_col,
  output logic [7:0]        rd_rows
);

  logic [7:0] cols_r [alks_pkg::KEY_COLUMNS];
  logic       wr_hit;
  logic       rd_hit;

  assign wr_hit = wr.en && ({1'b0, wr.col} < 5'(alks_pkg::KEY_COLUMNS));
  assign rd_hit = {1'b0, rd_col} < 5'(alks_pkg::KEY_COLUMNS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < alks_pkg::KEY_COLUMNS; i++) begin
        cols_r[i] <= 8'hff;
      end
    end else if (wr_hit) begin
      cols_r[wr.col[alks_pkg::KEY_IDX_W-1:0]] <= wr.rows;
    end
  end

  // Columns past the end of the matrix read as no key pressed.
  assign rd_rows = rd_hit ? cols_r[rd_col[alks_pkg::KEY_IDX_W-1:0]] : 8'hff;

endmodule

// ===== src/alks_check.sv =====
// Port-level checks for the addressable latch and keyboard scan block, bound to the top level.
module alks_check (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [alks_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The CA2 level is only raised when CA2 is driven.
  a_ca2_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[8])
    else $error("ca2 level without ca2 write");

  // The sound byte is zero unless a byte is strobed to the sound chip.
  a_sound_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[10] |-> out_tdata[18:11] == 8'h00)
    else $error("sound byte without strobe");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind addressable_latch_keyboard_scan alks_check u_alks_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb.sv =====
// Testbench for the addressable latch and keyboard scan block, with directed and random items.
module tb;

  typedef struct packed {
    alks_pkg::kind_t kind;
    logic [7:0]      data;
    logic [3:0]      col;
    logic [7:0]      rows;
  } bus_item_t;

  typedef struct packed {
    logic [7:0] port_a;
    logic       ca2_wr;
    logic       ca2_lvl;
    logic       snd_wr;
    logic [7:0] snd_byte;
    logic [7:0] latch;
    logic       screen;
  } scan_result_t;

  typedef struct packed {
    bus_item_t    item;
    logic         typed;
    scan_result_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  // Rows with typed set carry a hand-written expectation; the others go through the predictor.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{alks_pkg::KIND_TICK,   8'h00, 4'h0, 8'h00}, 1'b1,
      '{8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 8'hff, 1'b0}},
    '{'{alks_pkg::KIND_PORT_A, 8'hff, 4'h0, 8'h00}, 1'b1,
      '{8'hff, 1'b0, 1'b0, 1'b0, 8'h00, 8'hff, 1'b0}},
    '{'{alks_pkg::KIND_KEY,    8'h00, 4'h0, 8'h00}, 1'b1,
      '{8'hff, 1'b0, 1'b0, 1'b0, 8'h00, 8'hff, 1'b0}},
    '{'{alks_pkg::KIND_KEY,    8'h00, 4'h9, 8'hfe}, 1'b0, '0},
    '{'{alks_pkg::KIND_KEY,    8'hff, 4'hf, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_KEY,    8'h00, 4'ha, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h00, 4'h0, 8'hff}, 1'b1,
      '{8'hff, 1'b0, 1'b0, 1'b1, 8'hff, 8'hfe, 1'b0}},
    '{'{alks_pkg::KIND_PORT_B, 8'h00, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_A, 8'h00, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h08, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h04, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h0c, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h05, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h0d, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h01, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h09, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h03, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_A, 8'h00, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_A, 8'h09, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_A, 8'hfa, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_TICK,   8'h00, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h0b, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h02, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'h06, 4'h0, 8'h00}, 1'b0, '0},
    '{'{alks_pkg::KIND_PORT_B, 8'hf7, 4'h0, 8'h00}, 1'b0, '0}
  };

  logic                             clk;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [alks_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]                       in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [alks_pkg::OUT_TDATA_W-1:0] out_tdata;

  int send_idle = 0;
  int recv_stall = 0;
  int mismatch_count = 0;

  scan_result_t pending_results [$];

  // Predicted state of the block.
  logic [7:0] m_latch;
  logic [7:0] m_port_a;
  logic [3:0] m_scan_col;
  logic [7:0] m_keys [16];

  addressable_latch_keyboard_scan dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] col_rows(input logic [3:0] c);
    if (c < alks_pkg::KEY_COLUMNS) return m_keys[c];
    return 8'hff;
  endfunction

  // Row 0 of a column takes no part in the any-key test.
  function automatic logic any_pressed(input logic [7:0] r);
    return (r | 8'h01) != 8'hff;
  endfunction

  function automatic logic [7:0] kbd_read(input logic [7:0] b, output logic lvl);
    logic [7:0] r;
    m_scan_col = b[3:0];
    r = col_rows(m_scan_col);
    lvl = any_pressed(r);
    return {~r[b[6:4]], b[6:0]};
  endfunction

  function automatic scan_result_t apply_item(input bus_item_t it);
    scan_result_t res;
    logic [2:0]   idx;
    logic         val;
    res = '0;
    idx = it.data[2:0];
    val = it.data[3];
    case (it.kind)
      alks_pkg::KIND_PORT_A: begin
        m_port_a = it.data;
        if (!m_latch[alks_pkg::LB_SOUND_N]) begin
          res.snd_wr = 1'b1;
          res.snd_byte = it.data;
        end
        if (!m_latch[alks_pkg::LB_KBD_N]) begin
          m_port_a = kbd_read(m_port_a, res.ca2_lvl);
          res.ca2_wr = 1'b1;
        end
      end
      alks_pkg::KIND_PORT_B: begin
        // Rewriting the value a bit already holds has no side effect.
        if (m_latch[idx] != val) begin
          m_latch[idx] = val;
          res.screen = (idx == alks_pkg::LB_SCREEN_LO) || (idx == alks_pkg::LB_SCREEN_HI);
          if (!val) begin
            if (idx == alks_pkg::LB_SOUND_N) begin
              res.snd_wr = 1'b1;
              res.snd_byte = m_port_a;
            end else if (idx == alks_pkg::LB_PA_SET) begin
              m_port_a = 8'hff;
            end else if (idx == alks_pkg::LB_KBD_N) begin
              m_port_a = kbd_read(m_port_a, res.ca2_lvl);
              res.ca2_wr = 1'b1;
            end
          end
        end
      end
      alks_pkg::KIND_TICK: begin
        if (m_latch[alks_pkg::LB_KBD_N]) begin
          m_scan_col = m_scan_col + 4'd1;
          res.ca2_lvl = any_pressed(col_rows(m_scan_col));
          res.ca2_wr = 1'b1;
        end
      end
      default: begin
        if (it.col < alks_pkg::KEY_COLUMNS) m_keys[it.col] = it.rows;
      end
    endcase
    res.port_a = m_port_a;
    res.latch = m_latch;
    return res;
  endfunction

  task automatic send_item(input bus_item_t it, input logic typed, input scan_result_t exp);
    scan_result_t want;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.kind;
    in_tdata <= {4'b0, it.rows, it.col, it.data};
    do @(posedge clk); while (!in_tready);
    want = apply_item(it);
    if (typed) want = exp;
    pending_results.push_back(want);
  endtask

  task automatic run_random(input int n);
    bus_item_t it;
    int        pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      it.data = 8'($urandom_range(255));
      it.col = 4'($urandom_range(15));
      it.rows = 8'($urandom_range(255));
      if (pick < 30) begin
        it.kind = alks_pkg::KIND_PORT_A;
        // Mostly real columns, so that lookups hit the matrix.
        if ($urandom_range(3) != 0)
          it.data[3:0] = 4'($urandom_range(alks_pkg::KEY_COLUMNS - 1));
      end else if (pick < 60) begin
        it.kind = alks_pkg::KIND_PORT_B;
      end else if (pick < 80) begin
        it.kind = alks_pkg::KIND_TICK;
      end else begin
        it.kind = alks_pkg::KIND_KEY;
        if ($urandom_range(3) != 0) it.col = 4'($urandom_range(alks_pkg::KEY_COLUMNS - 1));
        case ($urandom_range(2))
          0: it.rows = 8'hff;
          1: it.rows = ~(8'h01 << $urandom_range(7));
          default: ;
        endcase
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %0h, got %0h at %0t", name, want, got, $time);
    end
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    out_tready <= ($urandom_range(99) >= recv_stall);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result item %0h at %0t", out_tdata, $time);
      end else begin
        want = pending_results.pop_front();
        check_field("port_a_value", want.port_a, out_tdata[7:0]);
        check_field("ca2_write", 8'(want.ca2_wr), 8'(out_tdata[8]));
        check_field("ca2_level", 8'(want.ca2_lvl), 8'(out_tdata[9]));
        check_field("sound_write", 8'(want.snd_wr), 8'(out_tdata[10]));
        check_field("sound_byte", want.snd_byte, out_tdata[18:11]);
        check_field("latch_outputs", want.latch, out_tdata[26:19]);
        check_field("screen_update", 8'(want.screen), 8'(out_tdata[27]));
      end
    end
  end

  initial begin
    m_latch = 8'hff;
    m_port_a = 8'h00;
    m_scan_col = 4'h0;
    foreach (m_keys[c]) m_keys[c] = 8'hff;
    send_idle = 6;
    recv_stall = 57;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].want);
    run_random(340);
    send_idle = 57;
    recv_stall = 6;
    run_random(330);
    send_idle = 0;
    recv_stall = 0;
    run_random(330);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/alks_pkg.sv
src/alks_keymat.sv
src/addressable_latch_keyboard_scan.sv
src/alks_check.sv
tb/tb.sv
